FILE: design/pidaw_pkg.sv
// Shared types and constants of the PID controller with anti-windup.
// Used by the controller, the datapath and the top level.
package pidaw_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 16;
	localparam int ALPHA_W   = 17;
	localparam int LIM_W     = 31;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT,
		ST_EDT,
		ST_P,
		ST_I1,
		ST_D,
		ST_DEC,
		ST_I2,
		ST_OUT
	} ctl_state_t;

	// operand pair selected for the shared multiplier
	typedef enum logic [2:0] {
		M_FILT,
		M_EDT,
		M_P,
		M_I1,
		M_D,
		M_I2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     zero;
		logic     raw_zero;
		logic     div_req;
		logic     mul_req;
		mul_sel_t msel;
		logic     commit;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic primed;
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/pid_antiwindup_controller_unit.sv
// PID controller with deadband, filtered derivative, anti-windup.
// An update runs one shared serial multiplier six times and one serial divider;
// the first update after reset or a clear skips the divider. A clear or
// zero-step transaction skips both. One transaction in flight.
// Reset: asynchronous, clears config and controller state; drive holds no value until the first result.
module pid_antiwindup_controller_unit import pidaw_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic signed [31:0]   error_in,
	input  logic [STEP_W-1:0]    step_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   drive
);
	dp_cmd_t    cmd;
	dp_status_t status;

	pidaw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.step_time (step_time),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	pidaw_dp #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.error_in  (error_in),
		.step_time (step_time),
		.cmd       (cmd),
		.out_stall (out_stall),
		.status    (status),
		.out_valid (out_valid),
		.drive     (drive)
	);

	// an accepted transaction keeps the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transaction");

	// a result is loaded only into a free output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result overwrote a pending output");

	// multiplier and divider never run in the same cycle
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_req && cmd.div_req))
		else $error("multiplier and divider requested together");

endmodule

FILE: design/pidaw_mul.sv
// Sequential shift-add multiplier with right shift, truncation toward zero
// and saturation. Depends on pidaw_pkg.
module pidaw_mul import pidaw_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int OW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req,
	input  logic signed [OW-1:0] a,
	input  logic signed [OW-1:0] b,
	input  logic                 sh16,
	output logic                 done,
	output logic signed [W-1:0]  res
);
	localparam int CW = $clog2(OW);
	localparam int PW = 2 * OW;

	logic          busy_q, done_q, neg_q, sh16_q;
	logic [CW-1:0] cnt_q;
	logic [OW-1:0] amag_q, hi_q, lo_q;
	logic [OW:0]   sum;
	logic [PW-1:0] prod, q, lim;
	logic [W-1:0]  m;

	// partial sum of one multiplier bit
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, amag_q} : '0);

	// iterate over the bits of b
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(OW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req && !done_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			{hi_q, lo_q} <= {sum, lo_q[OW-1:1]};
		end else if (req && !done_q) begin
			amag_q <= a[OW-1] ? OW'(-a) : a;
			lo_q   <= b[OW-1] ? OW'(-b) : b;
			hi_q   <= '0;
			neg_q  <= a[OW-1] ^ b[OW-1];
			sh16_q <= sh16;
		end
	end

	// shift, saturate and restore the sign
	always_comb begin
		prod = {hi_q, lo_q};
		q    = sh16_q ? (prod >> 16) : (prod >> F);
		lim  = neg_q ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		m    = (q > lim) ? lim[W-1:0] : q[W-1:0];
		res  = neg_q ? W'(~m + 1'b1) : m;
	end

	assign done = done_q;

endmodule

FILE: design/pidaw_div.sv
// Restoring divider, one quotient bit per cycle: diff * 2^16 / step,
// truncated toward zero and saturated. Depends on pidaw_pkg.
module pidaw_div import pidaw_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req,
	input  logic signed [W:0]     diff,
	input  logic [STEP_W-1:0]     dt,
	output logic                  done,
	output logic signed [W-1:0]   quo
);
	localparam int NW = W + 1 + STEP_W;
	localparam int CW = $clog2(NW);

	logic              busy_q, done_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [NW-1:0]     num_q, quo_q, lim;
	logic [STEP_W-1:0] rem_q, dt_q;
	logic [STEP_W:0]   trial;
	logic              fits;
	logic [W-1:0]      m;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, dt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req && !done_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	// shift in one dividend bit, subtract where it fits
	always_ff @(posedge clk) begin
		if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? STEP_W'(trial - {1'b0, dt_q}) : trial[STEP_W-1:0];
		end else if (req && !done_q) begin
			num_q <= {(diff[W] ? (W + 1)'(-diff) : diff), {STEP_W{1'b0}}};
			neg_q <= diff[W];
			dt_q  <= dt;
			rem_q <= '0;
			quo_q <= '0;
		end
	end

	always_comb begin
		lim = neg_q ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
		m   = (quo_q > lim) ? lim[W-1:0] : quo_q[W-1:0];
		quo = neg_q ? W'(~m + 1'b1) : m;
	end

	assign done = done_q;

endmodule

FILE: design/pidaw_ctrl.sv
// Sequencer of the PID update: steps the datapath through the divide and
// multiply phases and hands off the result. Depends on pidaw_pkg.
module pidaw_ctrl import pidaw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              kind,
	input  logic [STEP_W-1:0] step_time,
	input  dp_status_t        status,
	output logic              in_stall,
	output dp_cmd_t           cmd
);
	ctl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (kind || step_time == '0) ? ST_OUT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.primed || status.div_done) state_nx = ST_FILT;
			end
			ST_FILT: if (status.mul_done) state_nx = ST_EDT;
			ST_EDT:  if (status.mul_done) state_nx = ST_P;
			ST_P:    if (status.mul_done) state_nx = ST_I1;
			ST_I1:   if (status.mul_done) state_nx = ST_D;
			ST_D:    if (status.mul_done) state_nx = ST_DEC;
			ST_DEC:  state_nx = ST_I2;
			ST_I2:   if (status.mul_done) state_nx = ST_OUT;
			ST_OUT:  if (status.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.msel = M_FILT;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.clear = kind;
					cmd.zero  = kind || step_time == '0;
					cmd.load  = !kind && step_time != '0;
				end
			end
			ST_DIV: begin
				cmd.raw_zero = !status.primed;
				cmd.div_req  = status.primed;
			end
			ST_FILT: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_FILT;
			end
			ST_EDT: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_EDT;
			end
			ST_P: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_P;
			end
			ST_I1: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_I1;
			end
			ST_D: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_D;
			end
			ST_DEC:  cmd.commit = 1'b1;
			ST_I2: begin
				cmd.mul_req = 1'b1;
				cmd.msel    = M_I2;
			end
			ST_OUT:  cmd.emit = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: design/pidaw_dp.sv
// Datapath: configuration, controller state, operand selection, shared
// multiplier and divider, output register. Depends on pidaw_pkg, pidaw_mul,
// pidaw_div.
module pidaw_dp import pidaw_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic signed [31:0]    error_in,
	input  logic [STEP_W-1:0]     step_time,
	input  dp_cmd_t               cmd,
	input  logic                  out_stall,
	output dp_status_t            status,
	output logic                  out_valid,
	output logic signed [31:0]    drive
);
	localparam int OW = (W + 2 > 32) ? W + 2 : 32;
	localparam int LW = (W + 2 > 33) ? W + 2 : 33;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};

	function automatic logic signed [W-1:0] satw(input logic signed [LW-1:0] x);
		logic signed [W-1:0] r;
		if (x > LW'(VMAX)) r = VMAX;
		else if (x < LW'(VMIN)) r = VMIN;
		else r = x[W-1:0];
		return r;
	endfunction

	function automatic logic signed [LW-1:0] clamp(input logic signed [LW-1:0] x,
			input logic signed [LW-1:0] l);
		logic signed [LW-1:0] r;
		if (x > l) r = l;
		else if (x < -l) r = -l;
		else r = x;
		return r;
	endfunction

	// configuration registers
	logic signed [31:0]   gp_q, gi_q, gd_q;
	logic [LIM_W-1:0]     ilim_q, olim_q, dz_q;
	logic [ALPHA_W-1:0]   alpha_q;

	// controller state and per-update work registers
	logic signed [W-1:0]  integ_q, prev_q, df_q;
	logic                 primed_q;
	logic signed [W-1:0]  e_q, raw_q, nxt_q, p_q, iv_q, d_q;
	logic [STEP_W-1:0]    dt_q;
	logic                 zero_q, out_valid_q;
	logic signed [31:0]   drive_q;

	logic signed [LW-1:0] e_l, e_mag, u, ol, il;
	logic signed [W-1:0]  e_new, mres, dres, y;
	logic signed [OW-1:0] ma, mb;
	logic                 msh16, mdone, ddone, allow;
	logic [ALPHA_W-1:0]   alpha_c;
	logic signed [W:0]    diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q    <= '0;
			gi_q    <= '0;
			gd_q    <= '0;
			ilim_q  <= '0;
			olim_q  <= '0;
			dz_q    <= '0;
			alpha_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    gp_q    <= cfg_data;
				REG_GAIN_I:    gi_q    <= cfg_data;
				REG_GAIN_D:    gd_q    <= cfg_data;
				REG_INTEG_LIM: ilim_q  <= cfg_data[LIM_W-1:0];
				REG_OUT_LIM:   olim_q  <= cfg_data[LIM_W-1:0];
				REG_DEAD_ZONE: dz_q    <= cfg_data[LIM_W-1:0];
				REG_ALPHA:     alpha_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the error to the data width, then apply the deadband
	always_comb begin
		e_l   = LW'(error_in);
		e_new = satw(e_l);
		e_mag = e_new[W-1] ? -LW'(e_new) : LW'(e_new);
		if (e_mag < LW'(dz_q)) e_new = '0;
	end

	assign alpha_c = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign diff    = (W + 1)'(e_q) - (W + 1)'(prev_q);
	assign ol      = LW'(olim_q);
	assign il      = LW'(ilim_q);

	// select multiplier operands
	always_comb begin
		ma    = OW'(gp_q);
		mb    = OW'(e_q);
		msh16 = 1'b0;
		unique case (cmd.msel)
			M_FILT: begin
				ma    = OW'(alpha_c);
				mb    = OW'(raw_q) - OW'(df_q);
				msh16 = 1'b1;
			end
			M_EDT: begin
				ma    = OW'(e_q);
				mb    = OW'(dt_q);
				msh16 = 1'b1;
			end
			M_P: begin
				ma = OW'(gp_q);
				mb = OW'(e_q);
			end
			M_I1: begin
				ma = OW'(gi_q);
				mb = OW'(nxt_q);
			end
			M_D: begin
				ma = OW'(gd_q);
				mb = OW'(df_q);
			end
			M_I2: begin
				ma = OW'(gi_q);
				mb = OW'(integ_q);
			end
			default: ;
		endcase
	end

	pidaw_mul #(.W(W), .F(F), .OW(OW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd.mul_req),
		.a      (ma),
		.b      (mb),
		.sh16   (msh16),
		.done   (mdone),
		.res    (mres)
	);

	pidaw_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd.div_req),
		.diff   (diff),
		.dt     (dt_q),
		.done   (ddone),
		.quo    (dres)
	);

	// anti-windup decision on the unclamped output
	always_comb begin
		u     = LW'(p_q) + LW'(iv_q) + LW'(d_q);
		allow = (u <= ol && u >= -ol) || (u > ol && e_q < 0) || (u < -ol && e_q > 0);
		y     = zero_q ? '0 : satw(clamp(LW'(p_q) + LW'(iv_q) + LW'(d_q), ol));
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			prev_q   <= '0;
			df_q     <= '0;
			primed_q <= 1'b0;
		end else if (cmd.clear) begin
			integ_q  <= '0;
			prev_q   <= '0;
			df_q     <= '0;
			primed_q <= 1'b0;
		end else begin
			if (mdone && cmd.msel == M_FILT) begin
				df_q     <= satw(LW'(df_q) + LW'(mres));
				primed_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (allow) integ_q <= nxt_q;
				prev_q <= e_q;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q  <= e_new;
			dt_q <= step_time;
		end
		if (cmd.raw_zero) raw_q <= '0;
		if (ddone) raw_q <= dres;
		if (mdone) begin
			unique case (cmd.msel)
				M_EDT:       nxt_q <= W'(clamp(LW'(satw(LW'(integ_q) + LW'(mres))), il));
				M_P:         p_q   <= mres;
				M_I1, M_I2:  iv_q  <= mres;
				M_D:         d_q   <= mres;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.zero) zero_q <= 1'b1;
			else if (cmd.load) zero_q <= 1'b0;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) drive_q <= 32'(y);
	end

	assign status.div_done = ddone;
	assign status.mul_done = mdone;
	assign status.primed   = primed_q;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign drive           = drive_q;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the PID controller with anti-windup.
// Predicts each drive value in SystemVerilog; depends on pidaw_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
	import pidaw_pkg::*;

	localparam int  ITEMS     = 400;
	localparam int  LIMIT     = 1000000;
	localparam logic KIND_UPD = 1'b0;
	localparam logic KIND_CLR = 1'b1;
	localparam longint VMAX   = 64'sd2147483647;
	localparam longint VMIN   = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic signed [31:0] error_in = '0;
	logic [STEP_W-1:0] step_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] drive;

	pid_antiwindup_controller_unit DUT (.*);

	always #2 clk = ~clk;

	// predictor state and register copy
	longint kp, ki, kd, ilim, olim, dz, alpha_r;
	longint acc, last_err, dfilt;
	bit primed_m;

	logic signed [31:0] drive_q[$];
	int errors = 0;
	int cycles = 0;
	bit drain_hold = 1'b0;

	typedef struct {
		logic k;
		logic signed [31:0] e;
		logic [15:0] dt;
		bit fixed;
		logic signed [31:0] want;
	} row_t;

	function automatic longint sat32(longint x);
		if (x > VMAX) return VMAX;
		if (x < VMIN) return VMIN;
		return x;
	endfunction

	// exact product, magnitude shifted down, saturated
	function automatic longint prod_shift(longint a, longint b, int sh);
		bit neg;
		logic [127:0] m;
		logic [127:0] q;
		neg = (a < 0) != (b < 0);
		m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		q = m >> sh;
		if (neg) return (q > 128'd2147483648) ? VMIN : -longint'(q);
		return (q > 128'd2147483647) ? VMAX : longint'(q);
	endfunction

	function automatic longint rate_of(longint diff, longint dt);
		bit neg;
		logic [127:0] m, q;
		neg = diff < 0;
		m = 128'(neg ? -diff : diff);
		q = (m << 16) / 128'(dt);
		if (neg) return (q > 128'd2147483648) ? VMIN : -longint'(q);
		return (q > 128'd2147483647) ? VMAX : longint'(q);
	endfunction

	function automatic longint clamp_lim(longint x, longint lim);
		if (x > lim) return lim;
		if (x < -lim) return -lim;
		return x;
	endfunction

	function automatic logic signed [31:0] pid_drive(logic k, logic signed [31:0] ein,
			logic [15:0] dt);
		longint e, raw, nxt, p, iv, d, u, a;
		bit ok;
		if (k == KIND_CLR) begin
			acc = 0; last_err = 0; dfilt = 0; primed_m = 0;
			return 0;
		end
		if (dt == 0) return 0;
		e = longint'(ein);
		if ((e < 0 ? -e : e) < dz) e = 0;
		if (!primed_m) begin
			raw = 0;
			primed_m = 1;
		end else begin
			raw = rate_of(e - last_err, longint'(dt));
		end
		a = alpha_r > 65536 ? 65536 : alpha_r;
		dfilt = sat32(dfilt + prod_shift(a, raw - dfilt, 16));
		nxt = clamp_lim(sat32(acc + prod_shift(e, longint'(dt), 16)), ilim);
		p = prod_shift(kp, e, 16);
		iv = prod_shift(ki, nxt, 16);
		d = prod_shift(kd, dfilt, 16);
		u = p + iv + d;
		ok = (u <= olim && u >= -olim) || (u > olim && e < 0) || (u < -olim && e > 0);
		if (ok) acc = nxt;
		last_err = e;
		iv = prod_shift(ki, acc, 16);
		return 32'(sat32(clamp_lim(p + iv + d, olim)));
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// drop valid and wait for every expected drive
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_GAIN_P:    kp = longint'(signed'(v));
			REG_GAIN_I:    ki = longint'(signed'(v));
			REG_GAIN_D:    kd = longint'(signed'(v));
			REG_INTEG_LIM: ilim = longint'(v[30:0]);
			REG_OUT_LIM:   olim = longint'(v[30:0]);
			REG_DEAD_ZONE: dz = longint'(v[30:0]);
			REG_ALPHA:     alpha_r = longint'(v[16:0]);
			default: ;
		endcase
	endtask

	// send one transaction and queue its expected drive
	task automatic send(logic k, logic signed [31:0] e, logic [15:0] dt);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1; kind <= k; error_in <= e; step_time <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		drive_q.push_back(pid_drive(k, e, dt));
	endtask

	task automatic cfg_set(logic [31:0] p, logic [31:0] i, logic [31:0] d,
			logic [31:0] il, logic [31:0] ol, logic [31:0] z, logic [31:0] a);
		drain();
		write_reg(REG_GAIN_P, p); write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d); write_reg(REG_INTEG_LIM, il);
		write_reg(REG_OUT_LIM, ol); write_reg(REG_DEAD_ZONE, z);
		write_reg(REG_ALPHA, a);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rnd_err();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 400000)) - 200000);
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	// receive side: random stall, compare against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("unexpected drive %0d", drive);
			end else begin
				if (drive !== drive_q[0]) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("drive mismatch: expected %0d actual %0d", drive_q[0], drive);
				end
				void'(drive_q.pop_front());
			end
		end
		if ($urandom_range(0, 99) < 8) out_stall <= ~out_stall;
		else if (out_stall && $urandom_range(0, 99) < 30) out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	row_t rows[$];

	initial begin
		row_t r;
		kp = 0; ki = 0; kd = 0; ilim = 0; olim = 0; dz = 0; alpha_r = 0;
		acc = 0; last_err = 0; dfilt = 0; primed_m = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: all gains zero give zero drive
		rows.push_back('{KIND_UPD, 32'sh7fffffff, 16'hffff, 1, 0});
		rows.push_back('{KIND_UPD, 32'sh80000000, 16'h0001, 1, 0});
		foreach (rows[n]) begin
			r = rows[n];
			send(r.k, r.e, r.dt);
			if (r.fixed && drive_q[$] !== r.want) begin
				errors++;
				$display("row %0d: table expects %0d, predictor %0d", n, r.want, drive_q[$]);
			end
		end
		rows.delete();

		cfg_set(32'h00010000, 32'h00008000, 32'h00000400, 32'h00100000,
			32'h00080000, 32'h00000100, 32'd65536);
		rows.push_back('{KIND_UPD, 32'sh00010000, 16'h0000, 1, 0});
		rows.push_back('{KIND_UPD, 32'sh00010000, 16'h1000, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh00000080, 16'h1000, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh00020000, 16'h0001, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh7fffffff, 16'hffff, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh80000000, 16'h0001, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh7fffffff, 16'h0001, 0, 0});
		rows.push_back('{KIND_CLR, 32'sh12345678, 16'h4321, 1, 0});
		rows.push_back('{KIND_UPD, -32'sh00030000, 16'h8000, 0, 0});
		rows.push_back('{KIND_UPD, 32'sh00030000, 16'h8000, 0, 0});
		foreach (rows[n]) begin
			r = rows[n];
			send(r.k, r.e, r.dt);
			if (r.fixed && drive_q[$] !== r.want) begin
				errors++;
				$display("row %0d: table expects %0d, predictor %0d", n, r.want, drive_q[$]);
			end
		end

		// extreme gains, limits at max, alpha above one
		cfg_set(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h0, 32'h1ffff);
		for (int n = 0; n < 10; n++) send(n % 5 == 4, rnd_err(), 16'($urandom()));
		// hold the sender until the output drains
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			cfg_set($urandom(), $urandom(), $urandom(), $urandom_range(0, 32'h7fffffff),
				$urandom_range(0, 32'h7fffffff), $urandom_range(0, 4096),
				$urandom_range(0, 32'h1ffff));
			for (int n = 0; n < ITEMS / 4; n++)
				send($urandom_range(0, 19) == 0, rnd_err(),
					$urandom_range(0, 9) == 0 ? 16'h0 : 16'($urandom()));
		end

		drain();
		if (errors == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end

endmodule
